// ===== design/lcc_pkg.sv =====
package lcc_pkg;

    localparam int LCC_ADDRESS_BITS = 16;

    // bus access kinds carried in the input tuser
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // controller commands
    localparam logic [7:0] CMD_SET_POINTER   = 8'h24;
    localparam logic [7:0] CMD_TEXT_HOME     = 8'h40;
    localparam logic [7:0] CMD_TEXT_AREA     = 8'h41;
    localparam logic [7:0] CMD_GFX_HOME      = 8'h42;
    localparam logic [7:0] CMD_GFX_AREA      = 8'h43;
    localparam logic [7:0] CMD_MODE_FIRST    = 8'h80;
    localparam logic [7:0] CMD_MODE_LAST     = 8'h8F;
    localparam logic [7:0] CMD_DISPLAY_FIRST = 8'h90;
    localparam logic [7:0] CMD_DISPLAY_LAST  = 8'h9F;
    localparam logic [7:0] CMD_CURSOR_FIRST  = 8'hA0;
    localparam logic [7:0] CMD_CURSOR_LAST   = 8'hA7;
    localparam logic [7:0] CMD_AUTO_ENTER    = 8'hB0;
    localparam logic [7:0] CMD_AUTO_LEAVE    = 8'hB2;
    localparam logic [7:0] CMD_WRITE_INC     = 8'hC0;

    // status read data
    localparam logic [7:0] STATUS_READY      = 8'h03;
    localparam logic [7:0] STATUS_AUTO_READY = 8'h08;

    // setting change codes
    localparam logic [2:0] SET_NONE      = 3'd0;
    localparam logic [2:0] SET_TEXT_HOME = 3'd1;
    localparam logic [2:0] SET_TEXT_AREA = 3'd2;
    localparam logic [2:0] SET_GFX_HOME  = 3'd3;
    localparam logic [2:0] SET_GFX_AREA  = 3'd4;
    localparam logic [2:0] SET_MODE      = 3'd5;
    localparam logic [2:0] SET_DISPLAY   = 3'd6;
    localparam logic [2:0] SET_CURSOR    = 3'd7;

    // parameter latch fill levels
    localparam logic [1:0] PCNT_EMPTY = 2'd0;
    localparam logic [1:0] PCNT_ONE   = 2'd1;
    localparam logic [1:0] PCNT_TWO   = 2'd2;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_byte;
        logic [2:0]  setting_changed;
        logic [15:0] setting_value;
        logic        bad_command;
    } t_result;

endpackage

// ===== design/lcc_cmd_core.sv =====
module lcc_cmd_core import lcc_pkg::*; #(
    parameter int ADDRESS_BITS = LCC_ADDRESS_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_value,
    output t_result     o_result
);

    logic [ADDRESS_BITS-1:0] r_ptr, n_ptr;
    logic [7:0]              r_pfirst, n_pfirst;
    logic [7:0]              r_psecond, n_psecond;
    logic [1:0]              r_pcount, n_pcount;
    logic                    r_auto, n_auto;
    logic [15:0]             pair;
    t_result                 res;

    assign pair = {r_psecond, r_pfirst};

    always_comb begin
        n_ptr     = r_ptr;
        n_pfirst  = r_pfirst;
        n_psecond = r_psecond;
        n_pcount  = r_pcount;
        n_auto    = r_auto;
        res       = '0;
        unique case (t_kind'(i_kind))
            KIND_DATA: begin
                if (r_auto) begin
                    res.mem_write   = 1'b1;
                    res.mem_address = 16'(r_ptr);
                    res.mem_byte    = i_value;
                    n_ptr           = r_ptr + 1'b1;
                end else if (r_pcount == PCNT_EMPTY) begin
                    n_pfirst = i_value;
                    n_pcount = PCNT_ONE;
                end else if (r_pcount == PCNT_ONE) begin
                    n_psecond = i_value;
                    n_pcount  = PCNT_TWO;
                end else begin
                    // latch keeps the two newest bytes
                    n_pfirst  = r_psecond;
                    n_psecond = i_value;
                    n_pcount  = PCNT_TWO;
                end
            end
            KIND_CMD: begin
                n_pcount = PCNT_EMPTY;
                if (r_auto) begin
                    if (i_value == CMD_AUTO_LEAVE) begin
                        n_auto = 1'b0;
                    end else begin
                        res.bad_command = 1'b1;
                    end
                end else begin
                    unique case (i_value) inside
                        CMD_SET_POINTER: begin
                            n_ptr = pair[ADDRESS_BITS-1:0];
                        end
                        CMD_TEXT_HOME: begin
                            res.setting_changed = SET_TEXT_HOME;
                            res.setting_value   = pair;
                        end
                        CMD_TEXT_AREA: begin
                            res.setting_changed = SET_TEXT_AREA;
                            res.setting_value   = 16'(r_pfirst);
                        end
                        CMD_GFX_HOME: begin
                            res.setting_changed = SET_GFX_HOME;
                            res.setting_value   = pair;
                        end
                        CMD_GFX_AREA: begin
                            res.setting_changed = SET_GFX_AREA;
                            res.setting_value   = 16'(r_pfirst);
                        end
                        [CMD_MODE_FIRST:CMD_MODE_LAST]: begin
                            res.setting_changed = SET_MODE;
                            res.setting_value   = 16'(i_value[3:0]);
                        end
                        [CMD_DISPLAY_FIRST:CMD_DISPLAY_LAST]: begin
                            res.setting_changed = SET_DISPLAY;
                            res.setting_value   = 16'(i_value[3:0]);
                        end
                        [CMD_CURSOR_FIRST:CMD_CURSOR_LAST]: begin
                            res.setting_changed = SET_CURSOR;
                            res.setting_value   = 16'(i_value[2:0]);
                        end
                        CMD_AUTO_ENTER: begin
                            n_auto = 1'b1;
                        end
                        CMD_AUTO_LEAVE: begin
                            // already out of auto-write
                        end
                        CMD_WRITE_INC: begin
                            res.mem_write   = 1'b1;
                            res.mem_address = 16'(r_ptr);
                            res.mem_byte    = r_pfirst;
                            n_ptr           = r_ptr + 1'b1;
                        end
                        default: begin
                            res.bad_command = 1'b1;
                        end
                    endcase
                end
            end
            KIND_STATUS: begin
                res.status_byte = r_auto ? STATUS_AUTO_READY : STATUS_READY;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_pfirst  <= '0;
            r_psecond <= '0;
            r_pcount  <= PCNT_EMPTY;
            r_auto    <= 1'b0;
        end else if (i_fire) begin
            r_ptr     <= n_ptr;
            r_pfirst  <= n_pfirst;
            r_psecond <= n_psecond;
            r_pcount  <= n_pcount;
            r_auto    <= n_auto;
        end
    end

    assign o_result = res;

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.mem_write |=> r_ptr == $past(r_ptr) + 1'b1)
        else $error("address pointer did not step after a memory write");

    a_pcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && t_kind'(i_kind) == KIND_CMD |=> r_pcount == PCNT_EMPTY)
        else $error("parameter count not cleared by a command");

    a_auto_no_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_auto |=> $stable(r_pfirst) && $stable(r_psecond))
        else $error("parameter latch changed in auto-write");

endmodule

// ===== design/lcc_out_stage.sv =====
module lcc_out_stage import lcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // the result register can take a new word when empty or being drained
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== design/lcd_controller_command_interface.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser kind, tdata value
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser flags, tdata status/mem/setting
//
// one bus access per cycle while the output is not stalled; a taken access passes
// through the input register, then the result register
// the pointer and parameter latch update as an access moves into the result register
// a stalled output holds its word; the input register keeps taking words until it is full
// reset is synchronous, active low, and clears the pointer, latch and both valid flags
module lcd_controller_command_interface import lcc_pkg::*; #(
    parameter int ADDRESS_BITS = LCC_ADDRESS_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] value
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [7:0] status_byte, [23:8] mem_address,
                                       // [31:24] mem_byte, [47:32] setting_value
    output logic [4:0]  m_axis_tuser   // [0] mem_write, [3:1] setting_changed,
                                       // [4] bad_command
);

    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_value;
    logic       advance;
    logic       fire;
    logic       in_take;
    t_result    core_result;
    t_result    out_result;

    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind  <= s_axis_tuser;
            r_in_value <= s_axis_tdata;
        end
    end

    lcc_cmd_core #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_kind   (r_in_kind),
        .i_value  (r_in_value),
        .o_result (core_result)
    );

    lcc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_in_valid),
        .i_result  (core_result),
        .i_ready   (m_axis_tready),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .o_result  (out_result)
    );

    assign m_axis_tdata = {out_result.setting_value, out_result.mem_byte,
                           out_result.mem_address, out_result.status_byte};
    assign m_axis_tuser = {out_result.bad_command, out_result.setting_changed,
                           out_result.mem_write};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked output");

    a_mem_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !out_result.mem_write |->
            out_result.mem_address == 16'd0 && out_result.mem_byte == 8'd0)
        else $error("memory fields set without a memory write");

    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_result.bad_command |->
            !out_result.mem_write && out_result.setting_changed == SET_NONE
            && out_result.status_byte == 8'd0)
        else $error("rejected command produced an effect");

endmodule
